>>> rtl/flow_byte_counter_table_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef FLOW_BYTE_COUNTER_TABLE_UNIT_MACROS_SVH
`define FLOW_BYTE_COUNTER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FBCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FBCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fbct_pkg.sv
package fbct_pkg;

  // Five-tuple key; the first member is the most significant, so a plain
  // unsigned compare of the packed word gives the field-by-field order.
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
  } key_t;

  // One table entry: key plus its running byte total.
  typedef struct packed {
    key_t        key;
    logic [63:0] total;
  } entry_t;

  // Compare unit result.
  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

  // Result status codes.
  localparam logic [1:0] ST_UPDATE = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [31:0] MASK_RESET = 32'hFFFF_FFF0;

  // Output word layout.
  localparam int HELD_W  = 11;
  localparam int OUT_PAD = 5;

endpackage

>>> rtl/fbct_mem.sv
// Entry store: one write port and one read port, registered read data.
module fbct_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  fbct_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output fbct_pkg::entry_t         rdata
);

  fbct_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fbct_cmp.sv
// Key comparator shared by every search step and the final probe.
module fbct_cmp (
  input  fbct_pkg::key_t     stored,
  input  fbct_pkg::key_t     search,
  output fbct_pkg::cmp_res_t res
);

  always_comb begin
    res.less  = stored < search;
    res.equal = stored == search;
  end

endmodule

>>> rtl/flow_byte_counter_table_unit.sv
// Flow byte counter table. Each input word is one flow record; the source
// address is ANDed with the src_ip_mask register (written through cfg_wen /
// cfg_wdata while idle), the five-tuple is looked up by binary search in a
// sorted entry memory, and the byte count is added to that flow's 64-bit
// total. An unknown flow is inserted at its sorted place, moving the higher
// entries up one slot; with the table full it is dropped with status 2.
// Steps: accept, then search steps (memory read, then compare), up to
// ceil(log2(n+1)) steps for n flows held, then the final probe and the
// load of the result. An insert reads and rewrites every entry that moves
// up, then writes the new flow (the probe is skipped when the new flow
// sorts above all others); a drop at full goes straight to the result. The
// search loop is paced by the single registered read port of the entry
// memory. s_tready is high only between records; a result still held in
// the output register stalls the next record only at its final load. No
// clearing pass runs after reset: only the flow count, the state, the
// mask register and the output valid reset.
module flow_byte_counter_table_unit #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // protocol, src_ip, dst_ip, sport, dport, byte_count (low bit up)
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // flow_total, flows_held, zero pad (low bit up)
  output logic [79:0]  m_tdata,
  // status
  output logic [1:0]   m_tuser
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(TABLE_ENTRIES);
  localparam int HELD_W = fbct_pkg::HELD_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_STEP,
    S_PROBE,
    S_MISS,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_RESULT
  } state_t;

  state_t                state;
  logic [31:0]           src_ip_mask;
  logic [CNT_W-1:0]      occupancy;
  fbct_pkg::key_t        key;
  logic [31:0]           bytes;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hi;
  logic [CNT_W-1:0]      ptr;
  logic [1:0]            res_status;
  logic [63:0]           res_total;
  logic [HELD_W-1:0]     res_held;

  logic [CNT_W-1:0]      mid;
  logic [CNT_W-1:0]      ptr_m1;
  logic [63:0]           sum;
  logic                  we;
  logic [IDX_W-1:0]      wr_addr;
  fbct_pkg::entry_t      wr_data;
  logic [IDX_W-1:0]      rd_addr;
  fbct_pkg::entry_t      rd_data;
  fbct_pkg::cmp_res_t    cmp;

  // flow count as carried in the result: low bits of the count
  function automatic logic [HELD_W-1:0] held_of(input logic [CNT_W-1:0] c);
    logic [CNT_W+HELD_W-1:0] w;
    w = {{HELD_W{1'b0}}, c};
    return w[HELD_W-1:0];
  endfunction

  fbct_mem #(
    .DEPTH (TABLE_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  fbct_cmp u_cmp (
    .stored (rd_data.key),
    .search (key),
    .res    (cmp)
  );

  assign s_tready = (state == S_IDLE);
  assign mid      = lo + ((hi - lo) >> 1);
  assign ptr_m1   = ptr - CNT_W'(1);
  assign sum      = rd_data.total + {32'd0, bytes};

  // memory port steering
  always_comb begin
    rd_addr = lo[IDX_W-1:0];
    we      = 1'b0;
    wr_addr = lo[IDX_W-1:0];
    wr_data = rd_data;
    unique case (state)
      S_SEARCH: begin
        if (lo < hi) begin
          rd_addr = mid[IDX_W-1:0];
        end
      end
      S_PROBE: begin
        if (cmp.equal) begin
          we      = 1'b1;
          wr_data = '{key: rd_data.key, total: sum};
        end
      end
      S_SHIFT_RD: begin
        rd_addr = ptr_m1[IDX_W-1:0];
      end
      S_SHIFT_WR: begin
        we      = 1'b1;
        wr_addr = ptr[IDX_W-1:0];
      end
      S_INSERT: begin
        we      = 1'b1;
        wr_data = '{key: key, total: {32'd0, bytes}};
      end
      default: begin
      end
    endcase
  end

  // sequencer, config register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      occupancy   <= '0;
      src_ip_mask <= fbct_pkg::MASK_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        src_ip_mask <= cfg_wdata;
      end
      // a word taken while a new result loads is refilled below instead
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key.protocol <= s_tdata[7:0];
            key.src_ip   <= s_tdata[39:8] & src_ip_mask;
            key.dst_ip   <= s_tdata[71:40];
            key.sport    <= s_tdata[87:72];
            key.dport    <= s_tdata[103:88];
            bytes        <= s_tdata[135:104];
            lo           <= '0;
            hi           <= occupancy;
            state        <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (lo < hi) begin
            state <= S_STEP;
          end else if (lo < occupancy) begin
            state <= S_PROBE;
          end else begin
            state <= S_MISS;
          end
        end
        S_STEP: begin
          if (cmp.less) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_SEARCH;
        end
        S_PROBE: begin
          if (cmp.equal) begin
            res_status <= fbct_pkg::ST_UPDATE;
            res_total  <= sum;
            res_held   <= held_of(occupancy);
            state      <= S_RESULT;
          end else begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          if (occupancy == CAP) begin
            res_status <= fbct_pkg::ST_FULL;
            res_total  <= '0;
            res_held   <= held_of(occupancy);
            state      <= S_RESULT;
          end else begin
            ptr   <= occupancy;
            state <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          if (ptr > lo) begin
            state <= S_SHIFT_WR;
          end else begin
            state <= S_INSERT;
          end
        end
        S_SHIFT_WR: begin
          ptr   <= ptr_m1;
          state <= S_SHIFT_RD;
        end
        S_INSERT: begin
          occupancy  <= occupancy + CNT_W'(1);
          res_status <= fbct_pkg::ST_INSERT;
          res_total  <= {32'd0, bytes};
          res_held   <= held_of(occupancy + CNT_W'(1));
          state      <= S_RESULT;
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{fbct_pkg::OUT_PAD{1'b0}}, res_held, res_total};
            m_tuser  <= res_status;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/fbct_checker.sv
`include "flow_byte_counter_table_unit_macros.svh"

// Port-level checks for the flow byte counter table.
module fbct_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [79:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  // a stalled result word holds
  `FBCT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // one record at a time: ready drops right after an accept
  `FBCT_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "second record taken while busy")

  // only defined status codes appear
  `FBCT_ASSERT_SAME(a_status_code, clk, rst, m_tvalid, m_tuser != 2'd3, "undefined status code")

  // a dropped record reports a zero total
  `FBCT_ASSERT_SAME(a_drop_zero, clk, rst, m_tvalid && (m_tuser == fbct_pkg::ST_FULL), m_tdata[63:0] == 64'd0, "dropped record with nonzero total")

  // after an insert the table holds at least one flow
  `FBCT_ASSERT_SAME(a_insert_held, clk, rst, m_tvalid && (m_tuser == fbct_pkg::ST_INSERT), m_tdata[74:64] != 11'd0, "insert with empty table")

endmodule

bind flow_byte_counter_table_unit fbct_checker u_fbct_checker (.*);

>>> sim/tb_flow_byte_counter_table_unit.sv
module tb_flow_byte_counter_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_REPORTS   = 10;

  // One flow record as it goes into the block
  typedef struct {
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] byte_count;
  } flow_rec_t;

  // One result word as it comes out
  typedef struct {
    logic [1:0]                  status;
    logic [63:0]                 total;
    logic [fbct_pkg::HELD_W-1:0] held;
  } flow_result_t;

  // Sorted flow table shadow plus queue of pending results
  class flow_total_scoreboard;
    fbct_pkg::key_t keys [TABLE_ENTRIES];
    logic [63:0]    totals [TABLE_ENTRIES];
    int unsigned    held;
    logic [31:0]    src_mask;
    flow_result_t   pending_results [$];
    int unsigned    mismatches;

    function void clear();
      held = 0;
      src_mask = fbct_pkg::MASK_RESET;
      pending_results.delete();
      mismatches = 0;
    endfunction

    // Look the record up, update or insert, and queue the result it must give
    function void note_record(flow_rec_t r);
      fbct_pkg::key_t k;
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    mid;
      flow_result_t   res;
      k.protocol = r.protocol;
      k.src_ip   = r.src_ip & src_mask;
      k.dst_ip   = r.dst_ip;
      k.sport    = r.sport;
      k.dport    = r.dport;
      // lower bound: first slot whose key is not below k
      lo = 0;
      hi = held;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      if (lo < held && keys[lo] == k) begin
        totals[lo] = totals[lo] + 64'(r.byte_count);
        res.status = fbct_pkg::ST_UPDATE;
        res.total  = totals[lo];
      end else if (held >= TABLE_ENTRIES) begin
        res.status = fbct_pkg::ST_FULL;
        res.total  = 64'd0;
      end else begin
        for (int i = held; i > lo; i--) begin
          keys[i]   = keys[i-1];
          totals[i] = totals[i-1];
        end
        keys[lo]   = k;
        totals[lo] = 64'(r.byte_count);
        held++;
        res.status = fbct_pkg::ST_INSERT;
        res.total  = 64'(r.byte_count);
      end
      res.held = fbct_pkg::HELD_W'(held);
      pending_results.push_back(res);
    endfunction

    // Compare one output word against the oldest pending result
    function void check_result(logic [1:0] status, logic [63:0] total,
                               logic [fbct_pkg::HELD_W-1:0] held_out);
      flow_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result word: status %0d total %h held %0d",
                   status, total, held_out);
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status || total !== want.total ||
          held_out !== want.held) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: want status %0d total %h held %0d, got %0d %h %0d",
                   want.status, want.total, want.held, status, total, held_out);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [31:0]  cfg_wdata = 32'd0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // protocol, src_ip, dst_ip, sport, dport, byte_count (low bit up)
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // flow_total, flows_held, zero pad (low bit up)
  logic [79:0]  m_tdata;
  // status
  logic [1:0]   m_tuser;

  flow_total_scoreboard flow_sb;
  flow_rec_t            sent_records [$];
  int                   burst_left = 0;

  logic [15:0] ready_pat = 16'hFFFF;
  logic [3:0]  ready_pos = 4'd0;
  int          ready_age = 0;

  flow_byte_counter_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: replays a random 16-bit stall pattern, picked anew when ready_age runs out
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (ready_age == 0) begin
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        ready_age = 63;
      end else begin
        ready_age = ready_age - 1;
      end
      m_tready <= ready_pat[ready_pos];
      ready_pos = ready_pos + 4'd1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      flow_sb.check_result(m_tuser, m_tdata[63:0], m_tdata[64 +: fbct_pkg::HELD_W]);
  end

  function automatic flow_rec_t make_record(logic [7:0] protocol, logic [31:0] src_ip,
                                            logic [31:0] dst_ip, logic [15:0] sport,
                                            logic [15:0] dport, logic [31:0] byte_count);
    flow_rec_t r;
    r.protocol   = protocol;
    r.src_ip     = src_ip;
    r.dst_ip     = dst_ip;
    r.sport      = sport;
    r.dport      = dport;
    r.byte_count = byte_count;
    return r;
  endfunction

  // Known flow, near neighbor of a known flow, or a fresh random flow
  function automatic flow_rec_t pick_record(int reuse_pct);
    flow_rec_t r;
    int        sel;
    sel = $urandom_range(0, 99);
    if (sent_records.size() != 0 && sel < reuse_pct) begin
      r = sent_records[$urandom_range(0, sent_records.size() - 1)];
      // low address bits are what the default mask clears
      if ($urandom_range(0, 1) == 1) r.src_ip[3:0] = 4'($urandom);
    end else if (sent_records.size() != 0 && sel < reuse_pct + 20) begin
      r = sent_records[$urandom_range(0, sent_records.size() - 1)];
      case ($urandom_range(0, 2))
        0: r.dport = 16'($urandom);
        1: r.sport = 16'($urandom);
        default: r.dst_ip = $urandom;
      endcase
    end else begin
      r.protocol = 8'($urandom);
      r.src_ip   = $urandom;
      r.dst_ip   = $urandom;
      r.sport    = 16'($urandom);
      r.dport    = 16'($urandom);
    end
    case ($urandom_range(0, 7))
      0: r.byte_count = 32'd0;
      1: r.byte_count = 32'hFFFF_FFFF;
      default: r.byte_count = $urandom;
    endcase
    return r;
  endfunction

  // Drive one word; bursts of random length with random gaps between them
  task automatic send_record(input flow_rec_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tdata  <= {r.byte_count, r.dport, r.sport, r.dst_ip, r.src_ip, r.protocol};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    flow_sb.note_record(r);
    sent_records.push_back(r);
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input int reuse_pct);
    repeat (count) send_record(pick_record(reuse_pct));
  endtask

  // Mask write only once every result is out and the block has settled
  task automatic write_src_mask(input logic [31:0] value);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (flow_sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= value;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    flow_sb.src_mask = value;
  endtask

  initial begin
    flow_sb = new();
    flow_sb.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero key, masked-away address bits, top key, field-by-field order
    send_record(make_record(8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0));
    send_record(make_record(8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF));
    send_record(make_record(8'h00, 32'h0000_000F, 32'h0, 16'h0, 16'h0, 32'h1));
    send_record(make_record(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF));
    send_record(make_record(8'hFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            32'hFFFF_FFFF));
    send_record(make_record(8'h80, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd5));
    send_record(make_record(8'h7F, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd6));
    send_record(make_record(8'h80, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE, 32'd7));
    send_record(make_record(8'h80, 32'h0, 32'hFFFF_FFFF, 16'hFFFE, 16'hFFFF, 32'd8));
    send_record(make_record(8'h80, 32'h0, 32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF, 32'd9));
    send_record(make_record(8'h80, 32'h10, 32'h0, 16'h0, 16'h0, 32'd10));
    send_record(make_record(8'h01, 32'h0, 32'h0, 16'h0, 16'h1, 32'd11));
    send_record(make_record(8'h01, 32'h0, 32'h0, 16'h1, 16'h0, 32'd12));
    send_record(make_record(8'h00, 32'h0, 32'h0, 16'h0, 16'h1, 32'd13));
    send_record(make_record(8'h80, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA));
    send_record(make_record(8'h7F, 32'hFFFF_FFFA, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                            32'h5555_5555));
    send_record(make_record(8'h01, 32'h0, 32'h0, 16'h1, 16'h0, 32'hFFFF_FFFF));
    send_record(make_record(8'h00, 32'h0, 32'h0, 16'h0, 16'h0, 32'd1));
    send_record(make_record(8'h80, 32'h10, 32'h0, 16'h0, 16'h0, 32'd0));

    // random traffic under several mask settings
    run_random(200, 45);
    write_src_mask(32'hFFFF_FFFF);
    run_random(120, 50);
    write_src_mask(32'h0000_0000);
    run_random(80, 50);
    write_src_mask($urandom);
    run_random(80, 45);

    // full mask again, then a mask that clears high address bits
    write_src_mask(32'hFFFF_FFFF);
    run_random(110, 50);
    write_src_mask(32'hF0FF_FFFF);
    run_random(40, 55);

    s_tvalid <= 1'b0;
    while (flow_sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (flow_sb.mismatches == 0 && flow_sb.pending_results.size() == 0) begin
      $display("flow_byte_counter_table_unit test passed");
    end else begin
      $display("flow_byte_counter_table_unit test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #100ms;
    $display("flow_byte_counter_table_unit test failed");
    $finish;
  end

endmodule
